[src/wtw_pkg.sv]
package wtw_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ACT_W       = IDX_W + 1;

    localparam int FUNC_W     = 2;
    localparam int ENTRY_W    = 4;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int WD_W       = 3;
    localparam int MODE_W     = 4;
    localparam int DAYS_W     = 7;
    localparam int SETS_W     = 8;
    localparam int SEL_W      = 3;
    localparam int CHOSEN_W   = 5;
    localparam int KEY_W      = HOUR_W + MIN_W + SEC_W;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK,
        FN_WRITE,
        FN_SETS,
        FN_NONE
    } t_func;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACTIVE_SET,
        CFG_DEFAULT_MODE
    } t_cfg_reg;

    typedef struct packed {
        logic [HOUR_W-1:0] start_h;
        logic [MIN_W-1:0]  start_m;
        logic [HOUR_W-1:0] end_h;
        logic [MIN_W-1:0]  end_m;
        logic [MODE_W-1:0] mode;
        logic [DAYS_W-1:0] days;
        logic [SETS_W-1:0] sets;
    } t_entry;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_APPLY,
        OP_INIT,
        OP_SCAN,
        OP_REPORT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_SKIP,
        C_MORE,
        C_HOLD
    } t_cond;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE   = 3'd0;
    localparam t_pc PC_APPLY  = 3'd1;
    localparam t_pc PC_INIT   = 3'd2;
    localparam t_pc PC_SCAN   = 3'd3;
    localparam t_pc PC_REPORT = 3'd4;
    localparam t_pc PC_END    = 3'd5;

    typedef struct packed {
        t_op   op;
        logic  ready;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic ready;
    } t_ctrl;

    typedef struct packed {
        logic beat;
        logic skip;
        logic more;
        logic hold;
    } t_stat;

    // jump to target when cond holds, else fall through to pc + 1
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_NONE,   ready: 1'b1, cond: C_NO_BEAT, target: PC_IDLE};
            PC_APPLY:  w = '{op: OP_APPLY,  ready: 1'b0, cond: C_SKIP,    target: PC_IDLE};
            PC_INIT:   w = '{op: OP_INIT,   ready: 1'b0, cond: C_NEVER,   target: PC_IDLE};
            PC_SCAN:   w = '{op: OP_SCAN,   ready: 1'b0, cond: C_MORE,    target: PC_SCAN};
            PC_REPORT: w = '{op: OP_REPORT, ready: 1'b0, cond: C_HOLD,    target: PC_REPORT};
            default:   w = '{op: OP_NONE,   ready: 1'b0, cond: C_ALWAYS,  target: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [DAYS_W-1:0] day_bit(input logic [WD_W-1:0] wd);
        logic [DAYS_W-1:0] b;
        b = '0;
        if (wd < WD_W'(DAYS_W)) begin
            b = DAYS_W'(1) << wd;
        end
        return b;
    endfunction

    // following weekday with wrap; the out-of-range day stays out of range
    function automatic logic [WD_W-1:0] next_day(input logic [WD_W-1:0] wd);
        logic [WD_W-1:0] n;
        if (wd == WD_W'(DAYS_W - 1)) begin
            n = '0;
        end else if (wd < WD_W'(DAYS_W - 1)) begin
            n = wd + WD_W'(1);
        end else begin
            n = wd;
        end
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] time_key(input logic [HOUR_W-1:0] h,
                                                  input logic [MIN_W-1:0]  m,
                                                  input logic [SEC_W-1:0]  s);
        return {h, m, s};
    endfunction

endpackage

[src/weekly_time_window_program_selector.sv]
// A result beat is registered after the scan that its input beat starts, and only when the chosen
// entry differs from the active one. A new input beat is taken only once the sequencer is idle again;
// the microcode scan reads one table entry per cycle through a single read port.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active low) clears the table, registers, active entry and time-known flag.
module weekly_time_window_program_selector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [wtw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wtw_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry, hour_a, minute_a, sec_now, weekday_now, end_hour, end_minute,
    // mode_in, day_mask, set_mask, zero pad
    input  logic [wtw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [wtw_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // chosen_entry, fan_mode, zero pad
    output logic [wtw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import wtw_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    wtw_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    wtw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[src/wtw_sequencer.sv]
module wtw_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wtw_pkg::t_stat i_stat,
    output wtw_pkg::t_ctrl o_ctrl
);
    import wtw_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uword;
    logic   w_jump;

    assign w_uword      = ucode_rom(r_pc);
    assign o_ctrl.op    = w_uword.op;
    assign o_ctrl.ready = w_uword.ready;

    always_comb begin
        unique case (w_uword.cond)
            C_NEVER:   w_jump = 1'b0;
            C_ALWAYS:  w_jump = 1'b1;
            C_NO_BEAT: w_jump = !i_stat.beat;
            C_SKIP:    w_jump = i_stat.skip;
            C_MORE:    w_jump = i_stat.more;
            C_HOLD:    w_jump = i_stat.hold;
            default:   w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uword.target : r_pc + t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[src/wtw_datapath.sv]
module wtw_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wtw_pkg::t_ctrl                   i_ctrl,
    output wtw_pkg::t_stat                   o_stat,
    input  logic                             i_cfg_wr_en,
    input  logic [wtw_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wtw_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wtw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [wtw_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wtw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import wtw_pkg::*;

    t_entry               r_table [NUM_ENTRIES];
    t_func                r_func;
    logic [IN_DATA_W-1:0] r_data;
    logic [HOUR_W-1:0]    r_hour;
    logic [MIN_W-1:0]     r_min;
    logic [SEC_W-1:0]     r_sec;
    logic [WD_W-1:0]      r_wd;
    logic                 r_time_known;
    logic [ACT_W-1:0]     r_active;
    logic [IDX_W-1:0]     r_idx;
    logic [ACT_W-1:0]     r_win;
    logic [MODE_W-1:0]    r_win_mode;
    logic [SEL_W-1:0]     r_active_set;
    logic [MODE_W-1:0]    r_default_mode;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [ENTRY_W-1:0] w_entry;
    t_entry             w_new;
    logic [IDX_W-1:0]   w_wr_idx;
    logic               w_in_range;
    logic               w_beat;
    t_entry             w_cur;
    logic [KEY_W-1:0]   w_now;
    logic [KEY_W-1:0]   w_start;
    logic [KEY_W-1:0]   w_end;
    logic               w_hit;
    logic               w_differ;
    logic               w_out_free;
    logic [MODE_W-1:0]  w_rep_mode;

    // latched beat: entry[3:0] hour_a[8:4] minute_a[14:9] sec_now[20:15] weekday_now[23:21]
    // end_hour[28:24] end_minute[34:29] mode_in[38:35] day_mask[45:39] set_mask[53:46]
    assign w_entry       = r_data[3:0];
    assign w_new.start_h = r_data[8:4];
    assign w_new.start_m = r_data[14:9];
    assign w_new.end_h   = r_data[28:24];
    assign w_new.end_m   = r_data[34:29];
    assign w_new.mode    = r_data[38:35];
    assign w_new.days    = r_data[45:39];
    assign w_new.sets    = r_data[53:46];

    assign w_wr_idx   = IDX_W'(w_entry);
    assign w_in_range = ({3'b000, w_entry} < 7'(NUM_ENTRIES));
    assign w_beat     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_cur   = r_table[r_idx];
        w_now   = time_key(r_hour, r_min, r_sec);
        w_start = time_key(w_cur.start_h, w_cur.start_m, '0);
        w_end   = time_key(w_cur.end_h, w_cur.end_m, '0);
        w_hit   = 1'b0;
        if (w_start > w_end) begin
            if (w_now >= w_start) begin
                w_hit = |(w_cur.days & day_bit(r_wd));
            end else if (w_now < w_end) begin
                w_hit = |(w_cur.days & day_bit(next_day(r_wd)));
            end
        end else if (w_now >= w_start && w_now < w_end) begin
            w_hit = |(w_cur.days & day_bit(r_wd));
        end
        w_hit = w_hit && w_cur.sets[r_active_set];
    end

    assign w_differ   = (r_win != r_active);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_rep_mode = r_win[ACT_W-1] ? r_default_mode : r_win_mode;

    always_comb begin
        o_stat.beat = w_beat;
        o_stat.skip = (r_func == FN_NONE) ||
                      ((r_func != FN_TICK) && (!w_in_range || !r_time_known));
        o_stat.more = (r_idx != IDX_W'(NUM_ENTRIES - 1));
        o_stat.hold = w_differ && !w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_beat) begin
            r_func <= t_func'(s_axis_tuser);
            r_data <= s_axis_tdata;
        end
        if (i_ctrl.op == OP_APPLY && r_func == FN_TICK) begin
            r_hour <= r_data[8:4];
            r_min  <= r_data[14:9];
            r_sec  <= r_data[20:15];
            r_wd   <= r_data[23:21];
        end
        if (i_ctrl.op == OP_INIT) begin
            r_idx <= '0;
        end else if (i_ctrl.op == OP_SCAN) begin
            if (o_stat.more) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_hit) begin
                r_win_mode <= w_cur.mode;
            end
        end
        if (i_ctrl.op == OP_REPORT && w_differ && w_out_free) begin
            r_out_data <= {(OUT_DATA_W - CHOSEN_W - MODE_W)'(0), w_rep_mode,
                           CHOSEN_W'(r_win)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_table[i] <= '0;
            end
            r_time_known   <= 1'b0;
            r_active       <= '1;
            r_win          <= '1;
            r_active_set   <= '0;
            r_default_mode <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_addr))
                    CFG_ACTIVE_SET:   r_active_set   <= SEL_W'(i_cfg_wr_data);
                    CFG_DEFAULT_MODE: r_default_mode <= MODE_W'(i_cfg_wr_data);
                endcase
            end
            if (i_ctrl.op == OP_APPLY) begin
                if (r_func == FN_TICK) begin
                    r_time_known <= 1'b1;
                end else if (r_func != FN_NONE && w_in_range) begin
                    if (r_func == FN_WRITE) begin
                        r_table[w_wr_idx] <= w_new;
                    end else begin
                        r_table[w_wr_idx].sets <= w_new.sets;
                    end
                    if ({1'b0, w_wr_idx} == r_active) begin
                        r_active <= '1;
                    end
                end
            end
            if (i_ctrl.op == OP_INIT) begin
                r_win <= '1;
            end else if (i_ctrl.op == OP_SCAN && w_hit) begin
                r_win <= {1'b0, r_idx};
            end
            if (i_ctrl.op == OP_REPORT && w_differ && w_out_free) begin
                r_active    <= r_win;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // no beat is taken while reset is held
    assign s_axis_tready = i_ctrl.ready && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[src/wtw_checker.sv]
module wtw_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wtw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import wtw_pkg::*;

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:CHOSEN_W+MODE_W] == '0)
        else $error("result pad bits not zero");

    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("new result while input side idle");

endmodule

bind weekly_time_window_program_selector wtw_checker u_wtw_checker (.*);

[sim/wtw_selector_checker.sv]
`timescale 1ns / 100ps

module wtw_selector_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [wtw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wtw_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // entry, hour_a, minute_a, sec_now, weekday_now, end_hour, end_minute,
    // mode_in, day_mask, set_mask, zero pad
    input  logic [wtw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [wtw_pkg::FUNC_W-1:0]     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // chosen_entry, fan_mode, zero pad
    input  logic [wtw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                             o_pending,
    output int                             o_fail_count
);
    import wtw_pkg::*;

    localparam int PAD_W = IN_DATA_W - (ENTRY_W + 2 * HOUR_W + 2 * MIN_W + SEC_W + WD_W
                                        + MODE_W + DAYS_W + SETS_W);
    localparam int LAST_DAY  = DAYS_W - 1;

    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [SETS_W-1:0]  sets;
        logic [DAYS_W-1:0]  days;
        logic [MODE_W-1:0]  mode;
        logic [MIN_W-1:0]   end_m;
        logic [HOUR_W-1:0]  end_h;
        logic [WD_W-1:0]    wd;
        logic [SEC_W-1:0]   sec;
        logic [MIN_W-1:0]   min;
        logic [HOUR_W-1:0]  hour;
        logic [ENTRY_W-1:0] entry;
    } t_in_beat;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic [MODE_W-1:0]   mode;
    } t_report;

    t_entry            program_copy [NUM_ENTRIES];
    int                active_idx;
    logic [HOUR_W-1:0] now_h;
    logic [MIN_W-1:0]  now_m;
    logic [SEC_W-1:0]  now_s;
    logic [WD_W-1:0]   now_wd;
    logic              have_time;
    logic [SEL_W-1:0]  act_set;
    logic [MODE_W-1:0] dflt_mode;
    t_report           reports_due [$];
    int                fail_cnt = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_cnt++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic logic window_holds(input t_entry e, input logic [KEY_W-1:0] now,
                                          input logic [WD_W-1:0] wd);
        logic [KEY_W-1:0]  t_open;
        logic [KEY_W-1:0]  t_close;
        logic [WD_W-1:0]   wd_next;
        logic [DAYS_W-1:0] today;
        logic [DAYS_W-1:0] tomorrow;
        t_open  = {e.start_h, e.start_m, SEC_W'(0)};
        t_close = {e.end_h, e.end_m, SEC_W'(0)};
        today   = (wd <= LAST_DAY) ? (DAYS_W'(1) << wd) : '0;
        if (wd == LAST_DAY) begin
            wd_next = '0;
        end else if (wd < LAST_DAY) begin
            wd_next = wd + 1'b1;
        end else begin
            wd_next = wd;
        end
        tomorrow = (wd_next <= LAST_DAY) ? (DAYS_W'(1) << wd_next) : '0;
        if (t_open > t_close) begin
            if (now >= t_open) begin
                return |(e.days & today);
            end
            if (now < t_close) begin
                return |(e.days & tomorrow);
            end
            return 1'b0;
        end
        if (now < t_open || now >= t_close) begin
            return 1'b0;
        end
        return |(e.days & today);
    endfunction

    task automatic rescan();
        int      winner;
        t_report r;
        winner = -1;
        if (!have_time) begin
            return;
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (program_copy[i].sets[act_set] &&
                window_holds(program_copy[i], {now_h, now_m, now_s}, now_wd)) begin
                winner = i;
            end
        end
        if (winner == active_idx) begin
            return;
        end
        active_idx = winner;
        if (winner >= 0) begin
            r.chosen = CHOSEN_W'(winner);
            r.mode   = program_copy[winner[IDX_W-1:0]].mode;
        end else begin
            r.chosen = '1;
            r.mode   = dflt_mode;
        end
        reports_due.push_back(r);
    endtask

    task automatic apply_beat(input t_in_beat b, input t_func fn);
        case (fn)
            FN_TICK: begin
                now_h     = b.hour;
                now_m     = b.min;
                now_s     = b.sec;
                now_wd    = b.wd;
                have_time = 1'b1;
                rescan();
            end
            FN_WRITE, FN_SETS: begin
                if (int'(b.entry) < NUM_ENTRIES) begin
                    if (fn == FN_WRITE) begin
                        program_copy[b.entry] = '{start_h: b.hour, start_m: b.min,
                                                  end_h: b.end_h, end_m: b.end_m,
                                                  mode: b.mode, days: b.days, sets: b.sets};
                    end else begin
                        program_copy[b.entry].sets = b.sets;
                    end
                    if (int'(b.entry) == active_idx) begin
                        active_idx = -1;
                    end
                    rescan();
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                program_copy[i] = '0;
            end
            active_idx = -1;
            now_h      = '0;
            now_m      = '0;
            now_s      = '0;
            now_wd     = '0;
            have_time  = 1'b0;
            act_set    = '0;
            dflt_mode  = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_ACTIVE_SET:   act_set   = i_cfg_wr_data[SEL_W-1:0];
                    CFG_DEFAULT_MODE: dflt_mode = i_cfg_wr_data[MODE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.chosen = m_axis_tdata[CHOSEN_W-1:0];
                got.mode   = m_axis_tdata[CHOSEN_W +: MODE_W];
                if (reports_due.size() == 0) begin
                    report_mismatch("unexpected beat, chosen_entry",
                                    int'($signed(got.chosen)), 0);
                end else begin
                    want = reports_due.pop_front();
                    if (got.chosen !== want.chosen) begin
                        report_mismatch("chosen_entry", int'($signed(got.chosen)),
                                        int'($signed(want.chosen)));
                    end
                    if (got.mode !== want.mode) begin
                        report_mismatch("fan_mode", int'(got.mode), int'(want.mode));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_beat(t_in_beat'(s_axis_tdata), t_func'(s_axis_tuser));
            end
        end
        o_pending    = reports_due.size();
        o_fail_count = fail_cnt;
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import wtw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 170;
    localparam int GAP_STRETCH    = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int                    pending;
    int                    fail_count;
    int                    quiet_cycles = 0;
    logic                  gaps_on = 1'b1;
    logic [SEL_W-1:0]      cur_set = '0;

    // window bounds last written per entry, used to aim ticks at edges
    bit [HOUR_W-1:0]       win_sh [NUM_ENTRIES];
    bit [MIN_W-1:0]        win_sm [NUM_ENTRIES];
    bit [HOUR_W-1:0]       win_eh [NUM_ENTRIES];
    bit [MIN_W-1:0]        win_em [NUM_ENTRIES];

    weekly_time_window_program_selector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wtw_selector_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("weekly_time_window_program_selector regression: fail");
            $finish;
        end
    end

    // result sink with random stalls
    initial begin : sink
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = gaps_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_beat(
        input int e,    input int h,
        input int m,    input int s,
        input int wd,   input int eh,
        input int em,   input int mode,
        input int days, input int sets);
        return IN_DATA_W'({SETS_W'(sets), DAYS_W'(days), MODE_W'(mode), MIN_W'(em),
                           HOUR_W'(eh), WD_W'(wd), SEC_W'(s), MIN_W'(m), HOUR_W'(h),
                           ENTRY_W'(e)});
    endfunction

    task automatic send_beat(input t_func fn, input logic [IN_DATA_W-1:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic tick(input int h, input int m, input int s, input int wd);
        send_beat(FN_TICK, pack_beat($urandom, h, m, s, wd, $urandom, $urandom, $urandom,
                                     $urandom, $urandom));
    endtask

    task automatic put_entry(input int e, input int sh, input int sm, input int eh,
                             input int em, input int mode, input int days, input int sets);
        win_sh[e[IDX_W-1:0]] = HOUR_W'(sh);
        win_sm[e[IDX_W-1:0]] = MIN_W'(sm);
        win_eh[e[IDX_W-1:0]] = HOUR_W'(eh);
        win_em[e[IDX_W-1:0]] = MIN_W'(em);
        send_beat(FN_WRITE, pack_beat(e, sh, sm, $urandom, $urandom, eh, em, mode, days, sets));
    endtask

    task automatic put_sets(input int e, input int sets);
        send_beat(FN_SETS, pack_beat(e, $urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, sets));
    endtask

    task automatic cfg_write(input t_cfg_reg r, input int v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= r;
        i_cfg_wr_data <= CFG_DATA_W'(v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // hold off the sender until every result is in and the scan is done
    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int biased_sets();
        int sets;
        sets = $urandom_range(0, 255);
        if ($urandom_range(0, 9) < 7) begin
            sets = sets | (1 << cur_set);
        end
        return sets;
    endfunction

    task automatic random_item();
        int pick;
        int e;
        int sh, sm, eh, em;
        pick = $urandom_range(0, 99);
        e    = $urandom_range(0, NUM_ENTRIES - 1);
        if (pick < 18) begin
            if ($urandom_range(0, 19) == 0) begin
                sh = $urandom_range(0, 31);
                sm = $urandom_range(0, 63);
                eh = $urandom_range(0, 31);
                em = $urandom_range(0, 63);
            end else begin
                sh = $urandom_range(0, 23);
                sm = $urandom_range(0, 59);
                eh = $urandom_range(0, 23);
                em = $urandom_range(0, 59);
            end
            if ($urandom_range(0, 12) == 0) begin
                eh = sh;
                em = sm;
            end
            put_entry(e, sh, sm, eh, em, $urandom_range(0, 15), $urandom_range(0, 127),
                      biased_sets());
        end else if (pick < 28) begin
            put_sets(e, biased_sets());
        end else if (pick < 31) begin
            send_beat(FN_NONE, pack_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom, $urandom, $urandom));
        end else if (pick < 46) begin
            if ($urandom_range(0, 1) == 0) begin
                tick(int'(win_sh[e[IDX_W-1:0]]), int'(win_sm[e[IDX_W-1:0]]),
                     $urandom_range(0, 1) * 59, $urandom_range(0, 6));
            end else begin
                tick(int'(win_eh[e[IDX_W-1:0]]), int'(win_em[e[IDX_W-1:0]]),
                     $urandom_range(0, 1) * 59, $urandom_range(0, 6));
            end
        end else if (pick < 51) begin
            tick($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 7));
        end else begin
            tick($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                 $urandom_range(0, 6));
        end
    endtask

    initial begin : stimulus
        int set_val;
        int mode_val;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_ACTIVE_SET;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_TICK;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, register reset values
        put_entry(3, 8, 0, 17, 0, 7, 7'h7F, 8'h01);   // before any tick
        send_beat(FN_NONE, pack_beat(3, 12, 0, 0, 1, 13, 0, 1, 7'h7F, 8'hFF));
        tick(0, 0, 0, 0);
        tick(8, 0, 0, 1);                              // window start
        tick(16, 59, 59, 1);
        tick(17, 0, 0, 1);                             // window end, exclusive
        tick(12, 30, 45, 2);
        put_entry(3, 8, 0, 17, 0, 9, 7'h7F, 8'h01);   // rewrite of active entry
        put_sets(3, 8'h02);
        put_sets(3, 8'h03);
        put_entry(15, 22, 0, 6, 0, 15, 7'h01, 8'hFF); // crosses midnight
        tick(3, 0, 0, 6);                              // saturday wraps to day 0
        tick(23, 0, 0, 6);
        tick(23, 0, 0, 0);
        tick(3, 0, 0, 7);                              // weekday 7 matches nothing
        put_entry(15, 10, 0, 10, 0, 4, 7'h7F, 8'hFF); // empty window
        tick(10, 0, 0, 3);
        put_entry(0, 31, 63, 31, 63, 15, 7'h7F, 8'hFF);
        tick(31, 63, 63, 7);
        put_entry(0, 0, 0, 31, 63, 15, 7'h7F, 8'hFF);
        tick(31, 62, 63, 4);
        put_sets(0, 8'h00);
        put_entry(7, 20, 0, 20, 1, 2, 7'h10, 8'h80);
        tick(20, 0, 30, 4);

        for (int p = 0; p < PHASES; p++) begin
            drain_and_settle();
            set_val  = (p == 0) ? 7 : (p == 1) ? 0 : $urandom_range(0, 7);
            mode_val = (p == 0) ? 15 : (p == 1) ? 0 : $urandom_range(0, 15);
            cfg_write(CFG_ACTIVE_SET, set_val);
            cfg_write(CFG_DEFAULT_MODE, mode_val);
            cur_set = SEL_W'(set_val);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % GAP_STRETCH == 0) begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                if (n == PHASE_ITEMS / 2) begin
                    drain_and_settle();
                end
                random_item();
            end
        end

        drain_and_settle();
        if (fail_count == 0) begin
            $display("weekly_time_window_program_selector regression: pass");
        end else begin
            $display("weekly_time_window_program_selector regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/wtw_pkg.sv
src/wtw_sequencer.sv
src/wtw_datapath.sv
src/weekly_time_window_program_selector.sv
src/wtw_checker.sv
sim/wtw_selector_checker.sv
sim/tb_top.sv
